// ----- rtl/core/dpst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dpst_pkg;

	// descriptor store geometry
	localparam int NUM_SETS        = 512;
	localparam int DESCRIPTOR_BASE = 16384;
	localparam int WORDS_PER_SET   = 8;
	localparam int SET_W           = $clog2(NUM_SETS);
	localparam int ADDR_W          = SET_W + 3;
	localparam int DEPTH           = NUM_SETS * WORDS_PER_SET;

	// link address window, 18 bits hold the upper bound
	localparam logic [17:0] LINK_LO   = 18'(DESCRIPTOR_BASE);
	localparam logic [17:0] LINK_HI   = 18'(DESCRIPTOR_BASE + NUM_SETS * 32);
	localparam logic [15:0] LINK_NULL = 16'hFFFF;
	localparam logic [15:0] LINK_BASE = 16'(DESCRIPTOR_BASE);

	// opcodes
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_TRIGGER = 2'd2;
	localparam logic [1:0] OP_NOP     = 2'd3;

	// word positions within a set
	localparam logic [2:0] W_OPT  = 3'd0;
	localparam logic [2:0] W_SRC  = 3'd1;
	localparam logic [2:0] W_CNT  = 3'd2;
	localparam logic [2:0] W_DST  = 3'd3;
	localparam logic [2:0] W_BIDX = 3'd4;
	localparam logic [2:0] W_LINK = 3'd5;
	localparam logic [2:0] W_CIDX = 3'd6;
	localparam logic [2:0] W_CCNT = 3'd7;

	// option word bits
	localparam int OPT_SAM        = 0;
	localparam int OPT_DAM        = 1;
	localparam int OPT_FRAME_SYNC = 2;
	localparam int OPT_KEEP_SET   = 3;
	localparam int OPT_FWID_LSB   = 8;
	localparam int OPT_TCC_LSB    = 12;
	localparam int OPT_DONE_IRQ   = 20;
	localparam int OPT_MID_IRQ    = 21;
	localparam int OPT_DONE_CHAIN = 22;
	localparam int OPT_MID_CHAIN  = 23;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [8:0]  set_index;
		logic [2:0]  word_index;
		logic [31:0] write_data;
	} cmd_t;

	typedef struct packed {
		logic               request_valid;
		logic [31:0]        source_address;
		logic [31:0]        dest_address;
		logic [15:0]        array_bytes;
		logic [15:0]        array_count;
		logic signed [15:0] source_step;
		logic signed [15:0] dest_step;
		logic [4:0]         address_mode;
		logic [5:0]         completion_code;
		logic [3:0]         event_flags;
		logic [31:0]        read_data;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [31:0]       wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic        en;
		logic        dec;
		logic [31:0] a;
		logic [15:0] step;
	} alu_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/dpst_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dpst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/dpst_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dpst_alu (
	input  wire logic                clk,
	input  wire dpst_pkg::alu_req_t  req,
	output logic [31:0]              sum
);

	logic [31:0] operand;
	logic [31:0] sum_q;

	// sign-extended step, or all ones for a decrement
	assign operand = req.dec ? 32'hFFFF_FFFF : {{16{req.step[15]}}, req.step};

	// shared adder, result registered
	always_ff @(posedge clk) begin
		if (req.en) begin
			sum_q <= req.a + operand;
		end
	end

	assign sum = sum_q;

endmodule

`default_nettype wire

// ----- rtl/core/dpst_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dpst_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	input  wire dpst_pkg::cmd_t     cmd,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output dpst_pkg::rsp_t          rsp,
	output dpst_pkg::mem_req_t      mem_req,
	input  wire logic [31:0]        mem_rdata,
	output dpst_pkg::alu_req_t      alu_req,
	input  wire logic [31:0]        alu_sum
);

	localparam logic [3:0] ST_CLEAR   = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_RDWAIT  = 4'd2;
	localparam logic [3:0] ST_FETCH   = 4'd3;
	localparam logic [3:0] ST_FWAIT   = 4'd4;
	localparam logic [3:0] ST_CHECK   = 4'd5;
	localparam logic [3:0] ST_ALU_SRC = 4'd6;
	localparam logic [3:0] ST_ALU_DST = 4'd7;
	localparam logic [3:0] ST_ALU_CNT = 4'd8;
	localparam logic [3:0] ST_ALU_END = 4'd9;
	localparam logic [3:0] ST_WBACK   = 4'd10;
	localparam logic [3:0] ST_LINK    = 4'd11;
	localparam logic [3:0] ST_LWAIT   = 4'd12;
	localparam logic [3:0] ST_DONE    = 4'd13;

	logic [3:0]                  state_q;
	logic [2:0]                  cnt_q;
	logic [dpst_pkg::ADDR_W-1:0] clr_q;
	logic                        rd_pend_q;
	logic [2:0]                  rd_word_q;
	logic                        rsp_valid_q;

	logic [dpst_pkg::SET_W-1:0]  set_q;
	logic [dpst_pkg::SET_W-1:0]  from_q;
	logic [31:0]                 words_q [8];
	logic [31:0]                 src_new_q;
	logic [31:0]                 dst_new_q;
	logic [15:0]                 bcnt_new_q;
	logic [15:0]                 ccnt_new_q;
	dpst_pkg::rsp_t              res_q;
	dpst_pkg::rsp_t              rsp_q;

	logic                        cmd_accept;
	logic                        cmd_in_range;
	logic [dpst_pkg::SET_W-1:0]  cmd_set;
	logic [31:0]                 opt;
	logic [15:0]                 acnt;
	logic [15:0]                 bcnt;
	logic [15:0]                 ccnt;
	logic                        inner;
	logic                        count_zero;
	logic [15:0]                 lnk16;
	logic [17:0]                 link_ext;
	logic [15:0]                 link_off;
	logic                        link_ok;
	logic                        final_w;
	logic [2:0]                  wb_word;
	logic [31:0]                 wb_data;
	logic                        rsp_load;

	// request handshake
	assign cmd_ready    = (state_q == ST_IDLE);
	assign cmd_accept   = cmd_valid && cmd_ready;
	assign cmd_in_range = ({1'b0, cmd.set_index} < 10'(dpst_pkg::NUM_SETS));
	assign cmd_set      = cmd.set_index[dpst_pkg::SET_W-1:0];
	assign rsp_load     = !rsp_valid_q || rsp_ready;

	// fields of the fetched set
	assign opt        = words_q[dpst_pkg::W_OPT];
	assign acnt       = words_q[dpst_pkg::W_CNT][15:0];
	assign bcnt       = words_q[dpst_pkg::W_CNT][31:16];
	assign ccnt       = words_q[dpst_pkg::W_CCNT][15:0];
	assign inner      = !opt[dpst_pkg::OPT_FRAME_SYNC] && (bcnt > 16'd1);
	assign count_zero = (acnt == 16'd0) || (bcnt == 16'd0) || (ccnt == 16'd0);
	assign final_w    = !inner && (alu_sum[15:0] == 16'd0);

	// link address check
	assign lnk16    = words_q[dpst_pkg::W_LINK][15:0];
	assign link_ext = {2'b00, lnk16};
	assign link_off = lnk16 - dpst_pkg::LINK_BASE;
	assign link_ok  = (lnk16 != dpst_pkg::LINK_NULL) && (link_ext >= dpst_pkg::LINK_LO) &&
		(link_ext + 18'd32 <= dpst_pkg::LINK_HI) && (link_off[4:0] == 5'd0);

	// write-back word select
	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: begin
				wb_word = dpst_pkg::W_SRC;
				wb_data = src_new_q;
			end
			2'd1: begin
				wb_word = dpst_pkg::W_CNT;
				wb_data = {bcnt_new_q, acnt};
			end
			2'd2: begin
				wb_word = dpst_pkg::W_DST;
				wb_data = dst_new_q;
			end
			default: begin
				wb_word = dpst_pkg::W_CCNT;
				wb_data = {words_q[dpst_pkg::W_CCNT][31:16], ccnt_new_q};
			end
		endcase
	end

	// descriptor ram port
	always_comb begin
		mem_req = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = clr_q;
			end
			ST_IDLE: begin
				if (cmd_accept && cmd_in_range && cmd.opcode == dpst_pkg::OP_WRITE) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = {cmd_set, cmd.word_index};
					mem_req.wdata = cmd.write_data;
				end
				if (cmd_accept && cmd_in_range && cmd.opcode == dpst_pkg::OP_READ) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = {cmd_set, cmd.word_index};
				end
			end
			ST_FETCH: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = {set_q, cnt_q};
			end
			ST_WBACK: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = {set_q, wb_word};
				mem_req.wdata = wb_data;
			end
			ST_LINK, ST_LWAIT: begin
				mem_req.re    = (state_q == ST_LINK);
				mem_req.raddr = {from_q, cnt_q};
				mem_req.we    = rd_pend_q;
				mem_req.waddr = {set_q, rd_word_q};
				mem_req.wdata = mem_rdata;
			end
			default: begin
			end
		endcase
	end

	// shared adder requests
	always_comb begin
		alu_req = '0;
		unique case (state_q)
			ST_ALU_SRC: begin
				alu_req.en = 1'b1;
				alu_req.a  = words_q[dpst_pkg::W_SRC];
				if (!opt[dpst_pkg::OPT_SAM]) begin
					alu_req.step = inner ? words_q[dpst_pkg::W_BIDX][15:0] :
						words_q[dpst_pkg::W_CIDX][15:0];
				end
			end
			ST_ALU_DST: begin
				alu_req.en = 1'b1;
				alu_req.a  = words_q[dpst_pkg::W_DST];
				if (!opt[dpst_pkg::OPT_DAM]) begin
					alu_req.step = inner ? words_q[dpst_pkg::W_BIDX][31:16] :
						words_q[dpst_pkg::W_CIDX][31:16];
				end
			end
			ST_ALU_CNT: begin
				alu_req.en  = 1'b1;
				alu_req.dec = 1'b1;
				alu_req.a   = {16'd0, inner ? bcnt : ccnt};
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			clr_q       <= '0;
			rd_pend_q   <= 1'b0;
			rd_word_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= mem_req.re && (state_q == ST_FETCH || state_q == ST_LINK);
			rd_word_q <= cnt_q;
			// response register: loaded on handoff, cleared when taken
			if (state_q == ST_DONE && rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + dpst_pkg::ADDR_W'(1);
					if (clr_q == dpst_pkg::ADDR_W'(dpst_pkg::DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_accept) begin
						cnt_q <= '0;
						if (cmd_in_range && cmd.opcode == dpst_pkg::OP_READ) begin
							state_q <= ST_RDWAIT;
						end else if (cmd_in_range && cmd.opcode == dpst_pkg::OP_TRIGGER) begin
							state_q <= ST_FETCH;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_RDWAIT: state_q <= ST_DONE;
				ST_FETCH: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						state_q <= ST_FWAIT;
					end
				end
				ST_FWAIT: state_q <= ST_CHECK;
				ST_CHECK: state_q <= count_zero ? ST_DONE : ST_ALU_SRC;
				ST_ALU_SRC: state_q <= ST_ALU_DST;
				ST_ALU_DST: state_q <= ST_ALU_CNT;
				ST_ALU_CNT: state_q <= ST_ALU_END;
				ST_ALU_END: begin
					cnt_q   <= '0;
					state_q <= opt[dpst_pkg::OPT_KEEP_SET] ? ST_DONE : ST_WBACK;
				end
				ST_WBACK: begin
					if (cnt_q == 3'd3) begin
						cnt_q   <= '0;
						state_q <= res_q.event_flags[3] ? ST_LINK : ST_DONE;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_LINK: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						state_q <= ST_LWAIT;
					end
				end
				ST_LWAIT: state_q <= ST_DONE;
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// fetched words land in the cycle after their read, from the registered ram output
	always_ff @(posedge clk) begin
		if (rd_pend_q && (state_q == ST_FETCH || state_q == ST_FWAIT)) begin
			words_q[rd_word_q] <= mem_rdata;
		end
	end

	// result assembly and updated set values
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_accept) begin
					res_q <= '0;
					set_q <= cmd_set;
				end
			end
			ST_RDWAIT: res_q.read_data <= mem_rdata;
			ST_CHECK: begin
				if (!count_zero) begin
					res_q.request_valid   <= 1'b1;
					res_q.source_address  <= words_q[dpst_pkg::W_SRC];
					res_q.dest_address    <= words_q[dpst_pkg::W_DST];
					res_q.array_bytes     <= acnt;
					res_q.array_count     <= opt[dpst_pkg::OPT_FRAME_SYNC] ? bcnt : 16'd1;
					res_q.source_step     <= $signed(words_q[dpst_pkg::W_BIDX][15:0]);
					res_q.dest_step       <= $signed(words_q[dpst_pkg::W_BIDX][31:16]);
					res_q.address_mode    <= {opt[dpst_pkg::OPT_FWID_LSB +: 3], opt[1:0]};
					res_q.completion_code <= opt[dpst_pkg::OPT_TCC_LSB +: 6];
				end
			end
			ST_ALU_DST: src_new_q <= alu_sum;
			ST_ALU_CNT: dst_new_q <= alu_sum;
			ST_ALU_END: begin
				if (inner) begin
					bcnt_new_q <= alu_sum[15:0];
					ccnt_new_q <= ccnt;
				end else begin
					ccnt_new_q <= alu_sum[15:0];
					bcnt_new_q <= opt[dpst_pkg::OPT_FRAME_SYNC] ? bcnt :
						words_q[dpst_pkg::W_LINK][31:16];
				end
				from_q <= link_off[dpst_pkg::SET_W+4:5];
				res_q.event_flags <= {
					!opt[dpst_pkg::OPT_KEEP_SET] && final_w && link_ok,
					final_w ? opt[dpst_pkg::OPT_DONE_CHAIN] : opt[dpst_pkg::OPT_MID_CHAIN],
					final_w ? opt[dpst_pkg::OPT_DONE_IRQ] : opt[dpst_pkg::OPT_MID_IRQ],
					final_w
				};
			end
			ST_DONE: begin
				if (rsp_load) begin
					rsp_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	// no ram write while the set is being fetched, checked or its updates computed
	a_no_write_mid_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH || state_q == ST_FWAIT || state_q == ST_CHECK ||
		 state_q == ST_ALU_SRC || state_q == ST_ALU_DST || state_q == ST_ALU_CNT ||
		 state_q == ST_ALU_END) |-> !mem_req.we)
		else $error("ram write during set update");

	// an accepted in-range trigger starts the fetch
	a_trigger_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_accept && cmd_in_range && cmd.opcode == dpst_pkg::OP_TRIGGER) |=>
		(state_q == ST_FETCH && cnt_q == 3'd0))
		else $error("trigger did not start fetch");

	// a transfer request never carries a zero count
	a_nonzero_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.request_valid) |->
		(rsp_q.array_bytes != 16'd0 && rsp_q.array_count != 16'd0))
		else $error("request with zero count");

	// linking happens only on a final request
	a_link_final: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.event_flags[3]) |->
		(rsp_q.event_flags[0] && rsp_q.request_valid))
		else $error("link without final request");

	// flags only accompany a request
	a_flags_need_request: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.request_valid) |-> (rsp_q.event_flags == 4'd0))
		else $error("flags without request");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/dma_param_set_transfer_engine.sv -----
// a write or invalid request responds directly, a read after a ram wait state
// a trigger fetches and checks the set, ends if exhausted, updates addresses
// and counts, ends if static, writes back and may copy a linked set; one
// request in flight at a time; the single-write, single-read ram orders steps
// reset: asynchronous, active low; then a clearing pass writes zero to all
// 4096 descriptor words, one per cycle, with no request accepted meanwhile
`timescale 1ns / 1ps
`default_nettype none

module dma_param_set_transfer_engine (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	input  wire dpst_pkg::cmd_t cmd,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output dpst_pkg::rsp_t      rsp
);

	dpst_pkg::mem_req_t mem_req;
	dpst_pkg::alu_req_t alu_req;
	logic [31:0]        mem_rdata;
	logic [31:0]        alu_sum;

	// descriptor parameter ram
	dpst_ram #(
		.WIDTH(32),
		.DEPTH(dpst_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_req.we),
		.waddr(mem_req.waddr),
		.wdata(mem_req.wdata),
		.re   (mem_req.re),
		.raddr(mem_req.raddr),
		.rdata(mem_rdata)
	);

	// shared address and count adder
	dpst_alu u_alu (
		.clk(clk),
		.req(alu_req),
		.sum(alu_sum)
	);

	// sequencer
	dpst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.mem_req  (mem_req),
		.mem_rdata(mem_rdata),
		.alu_req  (alu_req),
		.alu_sum  (alu_sum)
	);

endmodule

`default_nettype wire

// ----- tb/dpst_checker.sv -----
`timescale 1ns / 1ps

module dpst_checker
	import dpst_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire logic cmd_ready,
	input  wire cmd_t cmd,
	input  wire logic rsp_valid,
	input  wire logic rsp_ready,
	input  wire rsp_t rsp,
	output int        failures,
	output int        outstanding,
	output int        requests_seen,
	output int        links_seen
);

	// shadow copy of the descriptor ram
	logic [31:0] param_ram [0:DEPTH-1];
	rsp_t        expected_rsp [$];

	initial begin
		failures      = 0;
		outstanding   = 0;
		requests_seen = 0;
		links_seen    = 0;
	end

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// one trigger: emit the request, then write back and maybe link
	function automatic rsp_t fire_set(input logic [8:0] set_sel);
		rsp_t        r;
		int          base;
		logic [31:0] opt, src, abcnt, dst, bidx, lnk, cidx, ccntw, link_addr;
		logic [15:0] acnt, bcnt, ccnt;
		logic        fin, linked;
		logic [31:0] copy_buf [0:WORDS_PER_SET-1];
		int          from;

		r      = '0;
		base   = int'(set_sel) * WORDS_PER_SET;
		opt    = param_ram[base + W_OPT];
		src    = param_ram[base + W_SRC];
		abcnt  = param_ram[base + W_CNT];
		dst    = param_ram[base + W_DST];
		bidx   = param_ram[base + W_BIDX];
		lnk    = param_ram[base + W_LINK];
		cidx   = param_ram[base + W_CIDX];
		ccntw  = param_ram[base + W_CCNT];
		acnt   = abcnt[15:0];
		bcnt   = abcnt[31:16];
		ccnt   = ccntw[15:0];
		linked = 1'b0;

		// exhausted set
		if (acnt == 0 || bcnt == 0 || ccnt == 0)
			return r;

		r.request_valid   = 1'b1;
		r.source_address  = src;
		r.dest_address    = dst;
		r.array_bytes     = acnt;
		r.array_count     = opt[OPT_FRAME_SYNC] ? bcnt : 16'd1;
		r.source_step     = bidx[15:0];
		r.dest_step       = bidx[31:16];
		r.address_mode    = {opt[OPT_FWID_LSB +: 3], opt[OPT_DAM], opt[OPT_SAM]};
		r.completion_code = opt[OPT_TCC_LSB +: 6];

		// advance within the frame, or step to the next frame
		if (!opt[OPT_FRAME_SYNC] && bcnt > 1) begin
			bcnt = bcnt - 16'd1;
			if (!opt[OPT_SAM]) src = src + sext16(bidx[15:0]);
			if (!opt[OPT_DAM]) dst = dst + sext16(bidx[31:16]);
			fin = 1'b0;
		end else begin
			if (!opt[OPT_FRAME_SYNC])
				bcnt = lnk[31:16];
			ccnt = ccnt - 16'd1;
			if (!opt[OPT_SAM]) src = src + sext16(cidx[15:0]);
			if (!opt[OPT_DAM]) dst = dst + sext16(cidx[31:16]);
			fin = (ccnt == 0);
		end

		// write-back and link reload
		if (!opt[OPT_KEEP_SET]) begin
			param_ram[base + W_SRC]  = src;
			param_ram[base + W_CNT]  = {bcnt, acnt};
			param_ram[base + W_DST]  = dst;
			param_ram[base + W_CCNT] = {ccntw[31:16], ccnt};
			link_addr = {16'h0, lnk[15:0]};
			if (fin && lnk[15:0] != LINK_NULL && link_addr >= 32'(DESCRIPTOR_BASE) &&
			    link_addr + 32 <= 32'(DESCRIPTOR_BASE + NUM_SETS * 32) &&
			    ((link_addr - 32'(DESCRIPTOR_BASE)) & 32'd31) == 0) begin
				from = int'((link_addr - 32'(DESCRIPTOR_BASE)) / 32) * WORDS_PER_SET;
				for (int i = 0; i < WORDS_PER_SET; i++)
					copy_buf[i] = param_ram[from + i];
				for (int i = 0; i < WORDS_PER_SET; i++)
					param_ram[base + i] = copy_buf[i];
				linked = 1'b1;
			end
		end

		r.event_flags[0] = fin;
		r.event_flags[1] = fin ? opt[OPT_DONE_IRQ] : opt[OPT_MID_IRQ];
		r.event_flags[2] = fin ? opt[OPT_DONE_CHAIN] : opt[OPT_MID_CHAIN];
		r.event_flags[3] = linked;
		return r;
	endfunction

	function automatic rsp_t predict_response(input cmd_t c);
		rsp_t r;
		int   addr;

		r    = '0;
		addr = int'(c.set_index) * WORDS_PER_SET + int'(c.word_index);
		if (int'(c.set_index) >= NUM_SETS)
			return r;
		case (c.opcode)
			OP_WRITE: begin
				param_ram[addr] = c.write_data;
			end
			OP_READ: begin
				r.read_data = param_ram[addr];
			end
			OP_TRIGGER: begin
				r = fire_set(c.set_index);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want,
	                             input logic [31:0] got);
		if (got !== want) begin
			failures++;
			if (failures <= 10)
				$display("mismatch on %s: expected %h, got %h", field, want, got);
		end
	endtask

	// responses are checked before the new request is predicted
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				param_ram[i] = '0;
			expected_rsp.delete();
			outstanding = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("response with nothing outstanding: %h", rsp);
				end else begin
					want = expected_rsp.pop_front();
					compare_field("request_valid", want.request_valid, rsp.request_valid);
					compare_field("source_address", want.source_address, rsp.source_address);
					compare_field("dest_address", want.dest_address, rsp.dest_address);
					compare_field("array_bytes", want.array_bytes, rsp.array_bytes);
					compare_field("array_count", want.array_count, rsp.array_count);
					compare_field("source_step", want.source_step, rsp.source_step);
					compare_field("dest_step", want.dest_step, rsp.dest_step);
					compare_field("address_mode", want.address_mode, rsp.address_mode);
					compare_field("completion_code", want.completion_code,
					              rsp.completion_code);
					compare_field("event_flags", want.event_flags, rsp.event_flags);
					compare_field("read_data", want.read_data, rsp.read_data);
					if (want.request_valid) requests_seen++;
					if (want.event_flags[3]) links_seen++;
				end
			end
			if (cmd_valid && cmd_ready)
				expected_rsp.push_back(predict_response(cmd));
			outstanding = expected_rsp.size();
		end
	end

endmodule

// ----- tb/dma_param_set_transfer_engine_tb.sv -----
`timescale 1ns / 1ps

module dma_param_set_transfer_engine_tb;
	import dpst_pkg::*;

	localparam int ITEMS       = 1600;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_PCT    = 19;
	localparam int POOL_SETS   = 16;

	logic clk;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int   failures, outstanding, requests_seen, links_seen;
	int   items_sent = 0;
	logic hold_done  = 1'b0;
	logic calm;

	// stretch of the run with no idling on either side
	assign calm = items_sent >= 900 && items_sent < 1150;

	dma_param_set_transfer_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	dpst_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.rsp           (rsp),
		.failures      (failures),
		.outstanding   (outstanding),
		.requests_seen (requests_seen),
		.links_seen    (links_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: random stalls plus one long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (!hold_done && items_sent >= 300) begin
				rsp_ready <= 1'b0;
				hold_done = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	function automatic cmd_t make_cmd(input logic [1:0] op, input logic [8:0] set_sel,
	                                  input logic [2:0] word, input logic [31:0] data);
		cmd_t c;
		c.opcode     = op;
		c.set_index  = set_sel;
		c.word_index = word;
		c.write_data = data;
		return c;
	endfunction

	// entered and left just after a falling edge; valid stays up between requests unless an idle gap is drawn
	task automatic send_cmd(input cmd_t c);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (!cmd_ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_word(input logic [8:0] set_sel, input logic [2:0] word,
	                          input logic [31:0] data);
		send_cmd(make_cmd(OP_WRITE, set_sel, word, data));
	endtask

	task automatic fire(input logic [8:0] set_sel);
		send_cmd(make_cmd(OP_TRIGGER, set_sel, 3'($urandom()), $urandom()));
	endtask

	function automatic logic [15:0] link_to(input int set_sel);
		return 16'(DESCRIPTOR_BASE + set_sel * 32);
	endfunction

	// program a set with random but mostly live content, then run it
	task automatic run_transfer_sequence();
		logic [8:0]  set_sel;
		logic [31:0] opt, upper;
		logic [15:0] acnt, bcnt, ccnt, link, reload;
		int          pick, shots;

		set_sel = ($urandom_range(99) < 85) ? 9'($urandom_range(POOL_SETS - 1))
		                                    : 9'($urandom());
		opt = $urandom();
		opt[OPT_KEEP_SET] = ($urandom_range(4) == 0);

		pick = $urandom_range(15);
		acnt = (pick == 0) ? 16'h0 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(1, 64));
		bcnt = ($urandom_range(19) == 0) ? 16'h0 : 16'($urandom_range(1, 3));
		ccnt = ($urandom_range(19) == 0) ? 16'h0 : 16'($urandom_range(1, 3));
		reload = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 3));

		pick = $urandom_range(9);
		case (pick)
			0, 1, 2, 3, 4: link = link_to($urandom_range(POOL_SETS - 1));
			5:             link = link_to(int'(set_sel));
			6:             link = LINK_NULL;
			7:             link = 16'($urandom());
			8:             link = link_to(NUM_SETS - 1);
			default: begin
				link = $urandom_range(1) ? link_to(NUM_SETS) : link_to(3) + 16'd16;
			end
		endcase

		upper = $urandom();
		write_word(set_sel, W_OPT, opt);
		write_word(set_sel, W_SRC, $urandom());
		write_word(set_sel, W_CNT, {bcnt, acnt});
		write_word(set_sel, W_DST, $urandom());
		write_word(set_sel, W_BIDX, $urandom());
		write_word(set_sel, W_LINK, {reload, link});
		write_word(set_sel, W_CIDX, $urandom());
		write_word(set_sel, W_CCNT, {upper[31:16], ccnt});

		shots = $urandom_range(1, 10);
		repeat (shots) begin
			if ($urandom_range(4) == 0)
				send_cmd(make_cmd(OP_READ, set_sel, 3'($urandom()), $urandom()));
			else
				fire(set_sel);
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// exhausted set, unused opcode, extreme word round trip
		fire(9'd0);
		send_cmd(make_cmd(OP_NOP, 9'd5, 3'd7, 32'hFFFF_FFFF));
		write_word(9'd511, W_CCNT, 32'hFFFF_FFFF);
		send_cmd(make_cmd(OP_READ, 9'd511, W_CCNT, 32'h0));

		// frame-synchronized set at the field limits, null link; second trigger finds it spent
		write_word(9'd1, W_OPT, (32'd1 << OPT_FRAME_SYNC) | (32'd1 << OPT_DONE_IRQ) |
		           (32'd1 << OPT_DONE_CHAIN) | (32'd7 << OPT_FWID_LSB) |
		           (32'h3F << OPT_TCC_LSB) | (32'd1 << OPT_SAM));
		write_word(9'd1, W_SRC, 32'hFFFF_FFFF);
		write_word(9'd1, W_CNT, 32'hFFFF_FFFF);
		write_word(9'd1, W_DST, 32'hFFFF_FFF0);
		write_word(9'd1, W_BIDX, 32'h8000_7FFF);
		write_word(9'd1, W_LINK, 32'hFFFF_FFFF);
		write_word(9'd1, W_CIDX, 32'h8000_7FFF);
		write_word(9'd1, W_CCNT, 32'hFFFF_0001);
		fire(9'd1);
		fire(9'd1);

		// array-synchronized set: intermediate request, then final with link reload
		write_word(9'd2, W_OPT, (32'd1 << OPT_MID_IRQ) | (32'd1 << OPT_MID_CHAIN) |
		           (32'd1 << OPT_DONE_IRQ) | (32'd1 << OPT_DAM));
		write_word(9'd2, W_CNT, 32'h0002_0010);
		write_word(9'd2, W_BIDX, 32'hFFF0_0010);
		write_word(9'd2, W_LINK, {16'h0001, link_to(3)});
		write_word(9'd2, W_CCNT, 32'h0000_0001);
		fire(9'd2);
		fire(9'd2);
		send_cmd(make_cmd(OP_READ, 9'd2, W_CNT, 32'h0));

		// static set keeps its words, so both triggers are final
		write_word(9'd4, W_OPT, (32'd1 << OPT_KEEP_SET) | (32'd1 << OPT_FRAME_SYNC));
		write_word(9'd4, W_CNT, 32'h0001_0001);
		write_word(9'd4, W_CCNT, 32'h0000_0001);
		fire(9'd4);
		fire(9'd4);

		// random part: mostly programmed sets, some raw noise
		while (items_sent < ITEMS) begin
			if ($urandom_range(99) < 25)
				send_cmd(make_cmd(2'($urandom()), 9'($urandom()), 3'($urandom()),
				                  $urandom()));
			else
				run_transfer_sequence();
		end
		cmd_valid <= 1'b0;

		while (outstanding != 0) @(negedge clk);
		repeat (40) @(negedge clk);

		$display("run covered %0d commands, %0d transfer requests, %0d link reloads",
		         items_sent, requests_seen, links_seen);
		$display("including one %0d-cycle response hold-off and a stall-free stretch",
		         HOLD_CYCLES);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
